// ===== rtl/core/sqm_pkg.sv =====
// sqm_pkg: shared constants and types for the square marker code decoder
// no dependencies; imported by the decoder top level and its checker
`timescale 1ns / 1ps

package sqm_pkg;

   localparam int GRID_CELLS       = 7;
   localparam int INNER_CELLS      = 5;
   localparam int CODE_W           = INNER_CELLS * INNER_CELLS;
   localparam int COUNT_W          = 11;
   localparam int CS_W             = 6;
   localparam int CC_W             = 3;
   localparam int CFG_IDX_W        = 3;
   localparam int IDX_OUT_W        = 2;
   localparam int ROT_W            = 2;
   localparam int ROTATIONS        = 4;
   localparam int DEF_MAX_CODES    = 4;
   localparam int DEF_MAX_CELL     = 32;
   localparam int RESET_CELL_SIZE  = 10;
   localparam int RESET_CODE_COUNT = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_CELL_SIZE  = 3'd0,
      REG_CODE_COUNT = 3'd1,
      REG_CODE_ZERO  = 3'd2,
      REG_CODE_ONE   = 3'd3,
      REG_CODE_TWO   = 3'd4,
      REG_CODE_THREE = 3'd5
   } reg_index_type;

endpackage

// ===== rtl/core/square_marker_code_decoder.sv =====
// square_marker_code_decoder: pixel stream cell counter, border check and code matcher
// depends on sqm_pkg
`timescale 1ns / 1ps

// usage
//  req channel: one binarized pixel per beat in raster order, req_patch_start
//  flags the first pixel of a patch and restarts counting; one pixel is taken
//  every cycle while req_ready is high.
//  rsp channel: one beat per completed patch (7 x 7 cells of cell_size pixels)
//  with found flag, border status, matching code index, rotation and the code
//  as read.
//  csr channel: always ready, register index on csr_index, data on csr_wdata;
//  cell size changes take effect on the next pixel.
//  result path: after the last pixel of a patch is taken, the result is registered
//  in the match stage, then in the rsp register, where rsp_valid shows the beat.
//  throughput: one pixel per cycle while req_ready is high, set by the single cell
//  counting stage; the stored code compare happens once per patch in the match stage.
//  stall: a finished result waits in the rsp register while pixels keep
//  flowing; req_ready drops only when a second result is ready and the first
//  has not been taken.
//  reset: clears position, cell counts, pending results and loads the
//  register defaults (cell size 10, one code in use, codes zero).
module square_marker_code_decoder #(
   parameter int MAX_CODES = sqm_pkg::DEF_MAX_CODES,
   parameter int MAX_CELL  = sqm_pkg::DEF_MAX_CELL
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_pixel_on,
   input  logic                           req_patch_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic                           rsp_border_ok,
   output logic [sqm_pkg::IDX_OUT_W-1:0]  rsp_marker_index,
   output logic [sqm_pkg::ROT_W-1:0]      rsp_rotation,
   output logic [sqm_pkg::CODE_W-1:0]     rsp_read_code,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sqm_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [sqm_pkg::CODE_W-1:0]     csr_wdata
);
   import sqm_pkg::*;

   localparam int POS_W = $clog2(GRID_CELLS * MAX_CELL + 1);
   localparam int THR_W = $clog2(MAX_CELL * MAX_CELL / 2 + 1);
   localparam int CX_W  = $clog2(GRID_CELLS);

   function automatic logic [CS_W-1:0] clamp_cs(input logic [CS_W-1:0] raw);
      logic [CS_W-1:0] cs;
      if (raw == '0) begin
         cs = CS_W'(1);
      end else if (raw > CS_W'(MAX_CELL)) begin
         cs = CS_W'(MAX_CELL);
      end else begin
         cs = raw;
      end
      return cs;
   endfunction

   function automatic logic [POS_W-1:0] cell_mult(input logic [CS_W-1:0] cs, input int k);
      logic [POS_W+CS_W-1:0] prod;
      prod = (POS_W+CS_W)'(cs) * (POS_W+CS_W)'(k);
      return prod[POS_W-1:0];
   endfunction

   function automatic logic [THR_W-1:0] cell_thr(input logic [CS_W-1:0] cs);
      logic [2*CS_W-1:0] area;
      area = (2*CS_W)'(cs) * (2*CS_W)'(cs);
      return THR_W'(area >> 1);
   endfunction

   function automatic logic [CODE_W-1:0] turn_cw(input logic [CODE_W-1:0] v);
      logic [CODE_W-1:0] o;
      o = '0;
      for (int r = 0; r < INNER_CELLS; r++) begin
         for (int c = 0; c < INNER_CELLS; c++) begin
            o[r*INNER_CELLS + c] = v[(INNER_CELLS-1-c)*INNER_CELLS + r];
         end
      end
      return o;
   endfunction

   // configuration
   logic [POS_W-1:0]  mult_ff [1:GRID_CELLS];
   logic [THR_W-1:0]  thr_ff;
   logic [CC_W-1:0]   code_count_ff;
   logic [CODE_W-1:0] codes_ff [MAX_CODES];
   logic              cs_wr;
   logic              cc_wr;
   logic              code_wr;
   logic [1:0]        code_slot;
   logic [CS_W-1:0]   cs_new;
   logic [CS_W-1:0]   cs_reset;

   assign csr_ready = 1'b1;
   assign cs_new    = clamp_cs(csr_wdata[CS_W-1:0]);
   assign cs_reset  = clamp_cs(CS_W'(RESET_CELL_SIZE));
   assign code_slot = 2'(csr_index - REG_CODE_ZERO);

   always_comb begin
      cs_wr   = 1'b0;
      cc_wr   = 1'b0;
      code_wr = 1'b0;
      case (csr_index)
         REG_CELL_SIZE:  cs_wr = csr_valid;
         REG_CODE_COUNT: cc_wr = csr_valid;
         REG_CODE_ZERO, REG_CODE_ONE, REG_CODE_TWO, REG_CODE_THREE: code_wr = csr_valid;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= GRID_CELLS; k++) begin
            mult_ff[k] <= cell_mult(cs_reset, k);
         end
         thr_ff        <= cell_thr(cs_reset);
         code_count_ff <= CC_W'(RESET_CODE_COUNT);
         for (int m = 0; m < MAX_CODES; m++) begin
            codes_ff[m] <= '0;
         end
      end else begin
         if (cs_wr) begin
            for (int k = 1; k <= GRID_CELLS; k++) begin
               mult_ff[k] <= cell_mult(cs_new, k);
            end
            thr_ff <= cell_thr(cs_new);
         end
         if (cc_wr) begin
            code_count_ff <= csr_wdata[CC_W-1:0];
         end
         for (int m = 0; m < MAX_CODES; m++) begin
            if (code_wr && code_slot == 2'(m)) begin
               codes_ff[m] <= csr_wdata;
            end
         end
      end
   end

   // cell counting stage
   logic [POS_W-1:0]   col_ff, col_in, cur_col;
   logic [POS_W-1:0]   row_ff, row_in, cur_row;
   logic [COUNT_W-1:0] cnt_ff  [GRID_CELLS];
   logic [COUNT_W-1:0] cnt_in  [GRID_CELLS];
   logic [COUNT_W-1:0] cur_cnt [GRID_CELLS];
   logic [COUNT_W-1:0] cnt_inc [GRID_CELLS];
   logic               border_fail_ff, border_fail_in, cur_border, upd_border;
   logic [CODE_W-1:0]  code_bits_ff, code_bits_in, cur_code, upd_code;
   logic [CX_W-1:0]    cx, cy;
   logic [POS_W:0]     col_p1, row_p1;
   logic               col_end, last_row, row_cell_end, emit;
   logic [GRID_CELLS-1:0] marks;
   logic               req_accept;

   assign req_accept = req_valid && req_ready;

   always_comb begin
      cur_col    = req_patch_start ? '0 : col_ff;
      cur_row    = req_patch_start ? '0 : row_ff;
      cur_border = req_patch_start ? 1'b0 : border_fail_ff;
      cur_code   = req_patch_start ? '0 : code_bits_ff;
      for (int i = 0; i < GRID_CELLS; i++) begin
         cur_cnt[i] = req_patch_start ? '0 : cnt_ff[i];
      end

      cx = '0;
      cy = '0;
      for (int k = 1; k < GRID_CELLS; k++) begin
         if (cur_col >= mult_ff[k]) cx = CX_W'(k);
         if (cur_row >= mult_ff[k]) cy = CX_W'(k);
      end

      cnt_inc = cur_cnt;
      if (req_pixel_on && cur_cnt[cx] != COUNT_MAX) begin
         cnt_inc[cx] = cur_cnt[cx] + COUNT_W'(1);
      end

      col_p1   = (POS_W+1)'(cur_col) + (POS_W+1)'(1);
      row_p1   = (POS_W+1)'(cur_row) + (POS_W+1)'(1);
      col_end  = col_p1 >= (POS_W+1)'(mult_ff[GRID_CELLS]);
      last_row = row_p1 >= (POS_W+1)'(mult_ff[GRID_CELLS]);
      row_cell_end = last_row;
      for (int k = 1; k < GRID_CELLS; k++) begin
         if (row_p1 == (POS_W+1)'(mult_ff[k])) row_cell_end = 1'b1;
      end

      upd_border = cur_border;
      upd_code   = cur_code;
      for (int x = 0; x < GRID_CELLS; x++) begin
         marks[x] = cnt_inc[x] > COUNT_W'(thr_ff);
         if ((x == 0 || x == GRID_CELLS-1 || cy == '0 || cy == CX_W'(GRID_CELLS-1))
             && marks[x]) begin
            upd_border = 1'b1;
         end
      end
      for (int r = 0; r < INNER_CELLS; r++) begin
         for (int c = 0; c < INNER_CELLS; c++) begin
            if (cy == CX_W'(r+1) && marks[c+1]) upd_code[r*INNER_CELLS + c] = 1'b1;
         end
      end

      col_in         = col_p1[POS_W-1:0];
      row_in         = cur_row;
      cnt_in         = cnt_inc;
      border_fail_in = cur_border;
      code_bits_in   = cur_code;
      emit           = 1'b0;
      if (col_end) begin
         col_in = '0;
         if (row_cell_end) begin
            for (int i = 0; i < GRID_CELLS; i++) begin
               cnt_in[i] = '0;
            end
            border_fail_in = upd_border;
            code_bits_in   = upd_code;
         end
         if (last_row) begin
            emit           = 1'b1;
            row_in         = '0;
            border_fail_in = 1'b0;
            code_bits_in   = '0;
         end else begin
            row_in = row_p1[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         border_fail_ff <= 1'b0;
         code_bits_ff   <= '0;
         for (int i = 0; i < GRID_CELLS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (req_accept) begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         border_fail_ff <= border_fail_in;
         code_bits_ff   <= code_bits_in;
         cnt_ff         <= cnt_in;
      end
   end

   // match stage
   logic              m_valid_ff, m_valid_in;
   logic [CODE_W-1:0] m_code_ff;
   logic              m_ok_ff;
   logic              out_free, m_adv;

   assign out_free  = !rsp_valid || rsp_ready;
   assign m_adv     = m_valid_ff && out_free;
   assign req_ready = !m_valid_ff || out_free;

   always_comb begin
      m_valid_in = m_valid_ff;
      if (req_accept && emit) begin
         m_valid_in = 1'b1;
      end else if (m_adv) begin
         m_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
      end
      if (req_accept && emit) begin
         m_code_ff <= upd_code;
         m_ok_ff   <= !upd_border;
      end
   end

   logic [CODE_W-1:0]    rot_code [ROTATIONS];
   logic [CC_W-1:0]      cnt_eff;
   logic                 hit;
   logic [IDX_OUT_W-1:0] hit_idx;
   logic [ROT_W-1:0]     hit_rot;

   always_comb begin
      rot_code[0] = m_code_ff;
      for (int r = 1; r < ROTATIONS; r++) begin
         rot_code[r] = turn_cw(rot_code[r-1]);
      end
      cnt_eff = (code_count_ff > CC_W'(MAX_CODES)) ? CC_W'(MAX_CODES) : code_count_ff;
      hit     = 1'b0;
      hit_idx = '0;
      hit_rot = '0;
      for (int m = 0; m < MAX_CODES; m++) begin
         for (int r = 0; r < ROTATIONS; r++) begin
            if (!hit && m_ok_ff && CC_W'(m) < cnt_eff && rot_code[r] == codes_ff[m]) begin
               hit     = 1'b1;
               hit_idx = IDX_OUT_W'(m);
               hit_rot = ROT_W'(r);
            end
         end
      end
   end

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic                 rsp_border_ok_ff;
   logic [IDX_OUT_W-1:0] rsp_marker_index_ff;
   logic [ROT_W-1:0]     rsp_rotation_ff;
   logic [CODE_W-1:0]    rsp_read_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= m_valid_ff;
      end
      if (m_adv) begin
         rsp_found_ff        <= hit;
         rsp_border_ok_ff    <= m_ok_ff;
         rsp_marker_index_ff <= hit_idx;
         rsp_rotation_ff     <= hit_rot;
         rsp_read_code_ff    <= m_code_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_border_ok    = rsp_border_ok_ff;
   assign rsp_marker_index = rsp_marker_index_ff;
   assign rsp_rotation     = rsp_rotation_ff;
   assign rsp_read_code    = rsp_read_code_ff;

endmodule

// ===== rtl/core/sqm_checker.sv =====
// sqm_checker: port level checks for the square marker code decoder
// depends on sqm_pkg; bound to square_marker_code_decoder below
`timescale 1ns / 1ps

module sqm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic                          rsp_border_ok,
   input logic [sqm_pkg::IDX_OUT_W-1:0] rsp_marker_index,
   input logic [sqm_pkg::ROT_W-1:0]     rsp_rotation,
   input logic [sqm_pkg::CODE_W-1:0]    rsp_read_code
);
   import sqm_pkg::*;

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a match needs a clean border
   a_found_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_border_ok)
      else $error("match reported with failed border");

   // no match means zero index and rotation
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_marker_index == '0 && rsp_rotation == '0)
      else $error("index or rotation set without match");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_border_ok) && $stable(rsp_marker_index)
         && $stable(rsp_rotation) && $stable(rsp_read_code))
      else $error("result beat changed while stalled");

endmodule

bind square_marker_code_decoder sqm_checker u_sqm_checker (.*);
